// ===== hdl/bbc_pkg.sv =====
// bbc_pkg: shared types, constants and codes for the block buffer cache core
// no dependencies

package bbc_pkg;

  localparam int unsigned BufferCountDefault = 16;

  localparam logic [2:0] OP_GET       = 3'd0;
  localparam logic [2:0] OP_PROBE     = 3'd1;
  localparam logic [2:0] OP_RELEASE   = 3'd2;
  localparam logic [2:0] OP_REL_DELAY = 3'd3;
  localparam logic [2:0] OP_START_WR  = 3'd4;
  localparam logic [2:0] OP_IO_DONE   = 3'd5;
  localparam logic [2:0] OP_FLUSH     = 3'd6;

  localparam logic [3:0] ST_HIT        = 4'd0;
  localparam logic [3:0] ST_MISS       = 4'd1;
  localparam logic [3:0] ST_WAIT_BUSY  = 4'd2;
  localparam logic [3:0] ST_WAIT_FREE  = 4'd3;
  localparam logic [3:0] ST_WRITEBACK  = 4'd4;
  localparam logic [3:0] ST_FOUND      = 4'd5;
  localparam logic [3:0] ST_NOT_FOUND  = 4'd6;
  localparam logic [3:0] ST_OK         = 4'd7;
  localparam logic [3:0] ST_BAD_DEVICE = 4'd8;
  localparam logic [3:0] ST_NOTHING    = 4'd9;

  localparam logic CFG_DEVICE_COUNT = 1'b0;
  localparam logic CFG_NO_DELAY     = 1'b1;

  typedef struct packed {
    logic [2:0]  operation;
    logic        no_device;
    logic [2:0]  device_major;
    logic [7:0]  device_minor;
    logic [15:0] block_number;
    logic [3:0]  buffer_index;
    logic        async_write;
    logic        io_error;
    logic        flush_all;
  } req_t;

  typedef struct packed {
    logic [3:0] status;
    logic [3:0] result_buffer;
    logic       contents_valid;
    logic       wake_buffer_waiters;
    logic       wake_free_waiters;
    logic       auto_released;
  } rsp_t;

  // controller to datapath
  typedef struct packed {
    logic capture;
    logic execute;
  } cmd_t;

endpackage

// ===== hdl/block_buffer_cache_lru_core.sv =====
// block_buffer_cache_lru_core: an accepted transaction is captured, then executed,
// then held as a registered result; a new transaction waits until the held result leaves
// the execute step does the parallel tag match and free-queue shift in the datapath
// the result register holds while the output is stalled
// reset: async active low, all tags invalid, free queue 0..N-1, no clearing pass
// depends on bbc_pkg, bbc_ctrl, bbc_dpath

module block_buffer_cache_lru_core #(
  parameter int unsigned BufferCount = bbc_pkg::BufferCountDefault
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  bbc_pkg::req_t in_data_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output bbc_pkg::rsp_t out_data_o,
  input  logic          cfg_valid_i,
  output logic          cfg_ready_o,
  input  logic          cfg_index_i,
  input  logic [7:0]    cfg_data_i
);

  bbc_pkg::cmd_t cmd;

  assign cfg_ready_o = 1'b1;

  bbc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd)
  );

  bbc_dpath #(.BufferCount(BufferCount)) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .req_i       (in_data_i),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .rsp_o       (out_data_o)
  );

endmodule

// ===== hdl/bbc_ctrl.sv =====
// bbc_ctrl: transaction sequencer, capture then execute then hold result
// depends on bbc_pkg

module bbc_ctrl (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_stall_o,
  output logic         out_valid_o,
  input  logic         out_stall_i,
  output bbc_pkg::cmd_t cmd_o
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_OUT  = 2'd2;

  logic [1:0] state_q, state_d;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (in_valid_i) state_d = S_EXEC;
      S_EXEC: state_d = S_OUT;
      S_OUT: begin
        if (!out_stall_i) state_d = in_valid_i ? S_EXEC : S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= S_IDLE;
    else         state_q <= state_d;
  end

  // input taken when idle or when the held result leaves
  assign in_stall_o    = !((state_q == S_IDLE) || ((state_q == S_OUT) && !out_stall_i));
  assign out_valid_o   = (state_q == S_OUT);
  assign cmd_o.capture = in_valid_i && !in_stall_o;
  assign cmd_o.execute = (state_q == S_EXEC);

endmodule

// ===== hdl/bbc_dpath.sv =====
// bbc_dpath: tags, flags, free queue and command execution
// depends on bbc_pkg

module bbc_dpath #(
  parameter int unsigned BufferCount = bbc_pkg::BufferCountDefault
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  bbc_pkg::cmd_t cmd_i,
  input  bbc_pkg::req_t req_i,
  input  logic          cfg_we_i,
  input  logic          cfg_index_i,
  input  logic [7:0]    cfg_data_i,
  output bbc_pkg::rsp_t rsp_o
);

  localparam int unsigned IdxW = $clog2(BufferCount);
  localparam int unsigned CntW = $clog2(BufferCount + 1);

  localparam int unsigned F_BUSY = 0;
  localparam int unsigned F_DONE = 1;
  localparam int unsigned F_DELWRI = 2;
  localparam int unsigned F_ASYNC = 3;
  localparam int unsigned F_ERROR = 4;
  localparam int unsigned F_WANTED = 5;

  logic [3:0] dev_count_q;
  logic [7:0] no_delay_q;
  bbc_pkg::req_t req_q;
  bbc_pkg::rsp_t rsp_q, rsp_d;

  logic [BufferCount-1:0] tv_q, tv_d;
  logic [10:0] tdev_q [BufferCount];
  logic [10:0] tdev_d [BufferCount];
  logic [15:0] tblk_q [BufferCount];
  logic [15:0] tblk_d [BufferCount];
  logic [5:0]  fl_q [BufferCount];
  logic [5:0]  fl_d [BufferCount];
  logic [IdxW-1:0] fo_q [BufferCount];
  logic [IdxW-1:0] fo_d [BufferCount];
  logic [CntW-1:0] fc_q, fc_d;
  logic fw_q, fw_d;

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dev_count_q <= 4'd8;
      no_delay_q  <= 8'd0;
    end else if (cfg_we_i) begin
      if (cfg_index_i == bbc_pkg::CFG_DEVICE_COUNT) dev_count_q <= cfg_data_i[3:0];
      else                                           no_delay_q  <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) req_q <= req_i;
  end

  // parallel tag match
  logic [10:0] dev;
  logic [BufferCount-1:0] match;
  logic hit;
  logic [IdxW-1:0] hit_idx;
  always_comb begin
    dev = {req_q.device_major, req_q.device_minor};
    hit = 1'b0;
    hit_idx = '0;
    for (int i = 0; i < BufferCount; i++) begin
      match[i] = tv_q[i] && tdev_q[i] == dev && tblk_q[i] == req_q.block_number;
    end
    for (int i = BufferCount - 1; i >= 0; i--) begin
      if (match[i]) begin
        hit = 1'b1;
        hit_idx = IdxW'(i);
      end
    end
  end

  // flush candidate: first queue slot whose buffer is dirty and matches
  logic fl_hit;
  logic [IdxW-1:0] fl_buf;
  always_comb begin
    fl_hit = 1'b0;
    fl_buf = '0;
    for (int i = BufferCount - 1; i >= 0; i--) begin
      if (CntW'(i) < fc_q && fl_q[fo_q[i]][F_DELWRI] &&
          (req_q.flush_all || (tv_q[fo_q[i]] && tdev_q[fo_q[i]] == dev))) begin
        fl_hit = 1'b1;
        fl_buf = fo_q[i];
      end
    end
  end

  // command execution
  logic [IdxW-1:0] tgt;
  logic do_remove, do_append, in_q, ridx_ok;
  logic [5:0] f;
  logic [2:0] tmaj;
  always_comb begin
    tv_d = tv_q;
    fl_d = fl_q;
    tdev_d = tdev_q;
    tblk_d = tblk_q;
    fw_d = fw_q;
    rsp_d = '0;
    rsp_d.status = bbc_pkg::ST_NOT_FOUND;
    tgt = '0;
    do_remove = 1'b0;
    do_append = 1'b0;
    ridx_ok = ({28'd0, req_q.buffer_index} < 32'(BufferCount));
    f = '0;
    tmaj = '0;
    case (req_q.operation)
      bbc_pkg::OP_GET: begin
        if (!req_q.no_device && {1'b0, req_q.device_major} >= dev_count_q) begin
          rsp_d.status = bbc_pkg::ST_BAD_DEVICE;
        end else if (!req_q.no_device && hit) begin
          tgt = hit_idx;
          rsp_d.result_buffer = 4'(hit_idx);
          if (fl_q[hit_idx][F_BUSY]) begin
            fl_d[hit_idx][F_WANTED] = 1'b1;
            rsp_d.status = bbc_pkg::ST_WAIT_BUSY;
          end else begin
            do_remove = 1'b1;
            fl_d[hit_idx][F_BUSY] = 1'b1;
            rsp_d.status = bbc_pkg::ST_HIT;
            rsp_d.contents_valid = fl_q[hit_idx][F_DONE];
          end
        end else if (fc_q == '0) begin
          fw_d = 1'b1;
          rsp_d.status = bbc_pkg::ST_WAIT_FREE;
        end else begin
          tgt = fo_q[0];
          rsp_d.result_buffer = 4'(fo_q[0]);
          do_remove = 1'b1;
          if (fl_q[tgt][F_DELWRI]) begin
            fl_d[tgt] = (fl_q[tgt] & 6'b100000) | 6'b001001;
            rsp_d.status = bbc_pkg::ST_WRITEBACK;
          end else begin
            fl_d[tgt] = 6'b000001;
            tv_d[tgt] = !req_q.no_device;
            tdev_d[tgt] = req_q.no_device ? 11'd0 : dev;
            tblk_d[tgt] = req_q.no_device ? 16'd0 : req_q.block_number;
            rsp_d.status = bbc_pkg::ST_MISS;
          end
        end
      end
      bbc_pkg::OP_PROBE: begin
        if ({1'b0, req_q.device_major} >= dev_count_q) begin
          rsp_d.status = bbc_pkg::ST_BAD_DEVICE;
        end else if (hit) begin
          rsp_d.status = bbc_pkg::ST_FOUND;
          rsp_d.result_buffer = 4'(hit_idx);
          rsp_d.contents_valid = fl_q[hit_idx][F_DONE];
        end
      end
      bbc_pkg::OP_RELEASE, bbc_pkg::OP_REL_DELAY,
      bbc_pkg::OP_START_WR, bbc_pkg::OP_IO_DONE: begin
        if (ridx_ok) begin
          tgt = IdxW'(req_q.buffer_index);
          rsp_d.result_buffer = req_q.buffer_index;
          rsp_d.status = bbc_pkg::ST_OK;
          f = fl_q[tgt];
          tmaj = tdev_q[tgt][10:8];
          do_append = 1'b0;
          if (req_q.operation == bbc_pkg::OP_REL_DELAY && tv_q[tgt] && no_delay_q[tmaj]) begin
            do_remove = 1'b1;
            fl_d[tgt] = (f & 6'b100000) | 6'b001001;
            rsp_d.status = bbc_pkg::ST_WRITEBACK;
          end else if (req_q.operation == bbc_pkg::OP_START_WR) begin
            do_remove = 1'b1;
            fl_d[tgt] = (f & 6'b100000) | {2'b00, req_q.async_write, 3'b001};
          end else if (req_q.operation == bbc_pkg::OP_IO_DONE && !f[F_ASYNC]) begin
            f[F_DONE] = 1'b1;
            f[F_ERROR] = f[F_ERROR] | req_q.io_error;
            rsp_d.wake_buffer_waiters = f[F_WANTED];
            f[F_WANTED] = 1'b0;
            fl_d[tgt] = f;
          end else begin
            // release path (plain, delayed, async completion)
            if (req_q.operation == bbc_pkg::OP_REL_DELAY) begin
              f[F_DELWRI] = 1'b1;
              f[F_DONE] = 1'b1;
            end
            if (req_q.operation == bbc_pkg::OP_IO_DONE) begin
              f[F_DONE] = 1'b1;
              f[F_ERROR] = f[F_ERROR] | req_q.io_error;
              rsp_d.auto_released = 1'b1;
            end
            rsp_d.wake_buffer_waiters = f[F_WANTED];
            rsp_d.wake_free_waiters = fw_q;
            fw_d = 1'b0;
            if (f[F_ERROR]) tv_d[tgt] = 1'b0;
            f[F_WANTED] = 1'b0;
            f[F_BUSY] = 1'b0;
            f[F_ASYNC] = 1'b0;
            fl_d[tgt] = f;
            do_append = 1'b1;
          end
        end
      end
      bbc_pkg::OP_FLUSH: begin
        rsp_d.status = bbc_pkg::ST_NOTHING;
        if (fl_hit) begin
          tgt = fl_buf;
          do_remove = 1'b1;
          fl_d[tgt] = (fl_q[tgt] & 6'b100000) | 6'b001001;
          rsp_d.status = bbc_pkg::ST_WRITEBACK;
          rsp_d.result_buffer = 4'(fl_buf);
        end
      end
      default: ;
    endcase
  end

  // free queue: remove target (shift up), optionally append at tail
  logic [BufferCount-1:0] pos_hit;
  logic [BufferCount-1:0] after;
  logic [CntW-1:0] fc_rm;
  always_comb begin
    in_q = 1'b0;
    for (int i = 0; i < BufferCount; i++) begin
      pos_hit[i] = (CntW'(i) < fc_q) && (fo_q[i] == tgt);
    end
    for (int i = 0; i < BufferCount; i++) begin
      after[i] = 1'b0;
      for (int j = 0; j <= i; j++) after[i] = after[i] | pos_hit[j];
    end
    in_q = |pos_hit;
    fc_rm = (in_q && (do_remove || do_append)) ? fc_q - CntW'(1) : fc_q;
    for (int i = 0; i < BufferCount; i++) begin
      if ((do_remove || do_append) && in_q && after[i] && i + 1 < BufferCount)
        fo_d[i] = fo_q[i+1];
      else
        fo_d[i] = fo_q[i];
    end
    fc_d = fc_rm;
    if (do_append) begin
      for (int i = 0; i < BufferCount; i++) begin
        if (CntW'(i) == fc_rm) fo_d[i] = tgt;
      end
      fc_d = fc_rm + CntW'(1);
    end
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tv_q <= '0;
      fc_q <= CntW'(BufferCount);
      fw_q <= 1'b0;
      for (int i = 0; i < BufferCount; i++) begin
        tdev_q[i] <= '0;
        tblk_q[i] <= '0;
        fl_q[i] <= '0;
        fo_q[i] <= IdxW'(i);
      end
    end else if (cmd_i.execute) begin
      tv_q <= tv_d;
      fc_q <= fc_d;
      fw_q <= fw_d;
      tdev_q <= tdev_d;
      tblk_q <= tblk_d;
      fl_q <= fl_d;
      fo_q <= fo_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.execute) rsp_q <= rsp_d;
  end

  assign rsp_o = rsp_q;

endmodule

// ===== hdl/bbc_checker.sv =====
// bbc_checker: port-level assertions for the cache core
// depends on bbc_pkg; bound to block_buffer_cache_lru_core

module bbc_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          in_valid_i,
  input logic          in_stall_o,
  input logic          out_valid_o,
  input logic          out_stall_i,
  input bbc_pkg::rsp_t out_data_o
);

  // a result follows an accepted transaction once it has passed the execute state
  a_lat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> ##1 out_valid_o) else $error("no result");

  // stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(out_data_o)))
    else $error("result changed");

  // no accept while a result is stuck
  a_noacc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |-> in_stall_o) else $error("accept while stalled");

  // status code in range
  a_st: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.status <= bbc_pkg::ST_NOTHING)) else $error("bad status");

endmodule

bind block_buffer_cache_lru_core bbc_checker u_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);
